// File: hw/rtl/rmst_pkg.sv
// Shared constants, operation codes and compare helper for the range-min segment tree.
package rmst_pkg;

  localparam int unsigned LeavesDef = 1024;
  localparam int unsigned LeafWDef  = 10;
  localparam int unsigned RangeWDef = 11;
  localparam int unsigned DataW     = 64;

  // Largest signed 64-bit value; empty nodes and empty ranges read as this.
  localparam logic [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // Signed minimum; ties return the first operand.
  function automatic logic [DataW-1:0] smin(logic [DataW-1:0] a, logic [DataW-1:0] b);
    return ($signed(a) <= $signed(b)) ? a : b;
  endfunction

endpackage

// File: hw/rtl/rmst_if.sv
// Valid/ready channel interfaces for request and result beats.
interface rmst_in_if #(
  parameter int unsigned LeafW  = rmst_pkg::LeafWDef,
  parameter int unsigned RangeW = rmst_pkg::RangeWDef
);
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [LeafW-1:0]                 leaf_index;
  logic signed [rmst_pkg::DataW-1:0] new_value;
  logic [RangeW-1:0]                range_start;
  logic [RangeW-1:0]                range_end;

  modport source (
    output valid, operation, leaf_index, new_value, range_start, range_end,
    input  ready
  );
  modport sink (
    input  valid, operation, leaf_index, new_value, range_start, range_end,
    output ready
  );
endinterface

interface rmst_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rmst_pkg::DataW-1:0] minimum;
  logic                              range_empty;

  modport source (
    output valid, minimum, range_empty,
    input  ready
  );
  modport sink (
    input  valid, minimum, range_empty,
    output ready
  );
endinterface

// File: hw/rtl/rmst_node_mem.sv
// Node store: one write port, two registered read ports.
module rmst_node_mem #(
  parameter int unsigned Depth = 2 * rmst_pkg::LeavesDef,
  parameter int unsigned Width = rmst_pkg::DataW,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: hw/rtl/range_min_segment_tree.sv
// Range-minimum segment tree with point update, one operation in flight.
//
// The block keeps a bottom-up segment tree of 2*LEAVES signed 64-bit nodes
// in one memory (one write port, two registered read ports). Leaf k lives
// at node LEAVES+k; node i holds the minimum of nodes 2i and 2i+1. After
// reset a clearing pass writes the largest signed value into every node,
// one node per cycle; in_i.ready stays low until it ends. An update beat
// writes the leaf in its accept cycle, then climbs one level per cycle:
// the sibling read issued in one cycle is folded and the parent written
// in the next. An update occupies the block until the root is written
// and gives no result beat; an update to a leaf at or beyond LEAVES is
// dropped in its accept cycle. A query beat clamps range_end to LEAVES
// and walks the two range bounds upward one level per cycle, reading up
// to two nodes per level through the two read ports; it takes the accept
// cycle, the walk and a finish step. An empty range (start >= clamped
// end) skips the walk, returns the largest signed value and sets
// range_empty. The result sits in an output register, so the next beat
// is accepted while a result still waits; a query only holds in its
// finish cycle when the previous result has not been taken.
module range_min_segment_tree #(
  parameter int unsigned LEAVES = rmst_pkg::LeavesDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmst_in_if.sink    in_i,
  rmst_out_if.source out_o
);

  localparam int unsigned DataW  = rmst_pkg::DataW;
  localparam int unsigned LeafW  = $clog2(LEAVES);
  localparam int unsigned RangeW = $clog2(LEAVES + 1);
  localparam int unsigned Nodes  = 2 * LEAVES;
  localparam int unsigned AddrW  = $clog2(Nodes);
  // Bound positions reach Nodes itself (exclusive end of the top level).
  localparam int unsigned PosW   = $clog2(Nodes + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_QUERY,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] pos_q, pos_d;      // node just written on the update climb
  logic [DataW-1:0] cur_q, cur_d;      // value of that node
  logic [PosW-1:0]  lo_q, lo_d;
  logic [PosW-1:0]  hi_q, hi_d;
  logic [DataW-1:0] acc_l_q, acc_l_d;
  logic [DataW-1:0] acc_r_q, acc_r_d;
  logic             take_l_q, take_l_d; // read data on port a belongs to left acc
  logic             take_r_q, take_r_d;
  logic             empty_q, empty_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_min_q, out_min_d;
  logic             out_empty_q, out_empty_d;

  // Memory ports
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr_a;
  logic [AddrW-1:0] mem_raddr_b;
  logic [DataW-1:0] mem_rdata_a;
  logic [DataW-1:0] mem_rdata_b;

  // Request decode
  logic             in_ready;
  logic             accept;
  logic             is_query;
  logic [LeafW-1:0] leaf_idx;
  logic             leaf_ok;
  logic [AddrW-1:0] leaf_node;
  logic [RangeW-1:0] end_clamped;
  logic             range_empty;
  logic [PosW-1:0]  lo_node;
  logic [PosW-1:0]  hi_node;

  // Datapath terms
  logic [AddrW-1:0] parent;
  logic [DataW-1:0] parent_val;
  logic [DataW-1:0] acc_l_fold;
  logic [DataW-1:0] acc_r_fold;
  logic             walk_more;
  logic             out_free;

  rmst_node_mem #(
    .Depth (Nodes),
    .Width (DataW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign in_ready = (state_q == ST_IDLE);
  assign accept   = in_i.valid && in_ready;
  assign is_query = (in_i.operation == rmst_pkg::OP_QUERY);

  assign leaf_idx  = in_i.leaf_index;
  assign leaf_ok   = ({1'b0, leaf_idx} < (LeafW + 1)'(LEAVES));
  assign leaf_node = AddrW'(LEAVES) + AddrW'(leaf_idx);

  // End bound is clamped to the leaf count; start is not.
  assign end_clamped = (in_i.range_end > RangeW'(LEAVES)) ? RangeW'(LEAVES) : in_i.range_end;
  assign range_empty = (in_i.range_start >= end_clamped);
  assign lo_node     = PosW'(in_i.range_start) + PosW'(LEAVES);
  assign hi_node     = PosW'(end_clamped) + PosW'(LEAVES);

  // Update climb: sibling data arrives, parent gets the min.
  assign parent     = pos_q >> 1;
  assign parent_val = rmst_pkg::smin(cur_q, mem_rdata_a);

  // Query walk: fold the reads issued last cycle.
  assign acc_l_fold = take_l_q ? rmst_pkg::smin(acc_l_q, mem_rdata_a) : acc_l_q;
  assign acc_r_fold = take_r_q ? rmst_pkg::smin(mem_rdata_b, acc_r_q) : acc_r_q;
  assign walk_more  = (lo_q < hi_q);

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    acc_l_d     = acc_l_q;
    acc_r_d     = acc_r_q;
    take_l_d    = take_l_q;
    take_r_d    = take_r_q;
    empty_d     = empty_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_min_d   = out_min_q;
    out_empty_d = out_empty_q;

    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = rmst_pkg::MaxVal;
    mem_raddr_a = lo_q[AddrW-1:0];
    // hi-1 for odd hi is hi with bit 0 cleared
    mem_raddr_b = {hi_q[AddrW-1:1], 1'b0};

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = rmst_pkg::MaxVal;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Nodes - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          if (is_query) begin
            lo_d     = lo_node;
            hi_d     = hi_node;
            acc_l_d  = rmst_pkg::MaxVal;
            acc_r_d  = rmst_pkg::MaxVal;
            take_l_d = 1'b0;
            take_r_d = 1'b0;
            empty_d  = range_empty;
            state_d  = range_empty ? ST_FINISH : ST_QUERY;
          end else if (leaf_ok) begin
            mem_we      = 1'b1;
            mem_waddr   = leaf_node;
            mem_wdata   = in_i.new_value;
            mem_raddr_a = leaf_node ^ AddrW'(1);
            pos_d       = leaf_node;
            cur_d       = in_i.new_value;
            state_d     = ST_UPDATE;
          end
        end
      end

      ST_UPDATE: begin
        mem_we      = 1'b1;
        mem_waddr   = parent;
        mem_wdata   = parent_val;
        mem_raddr_a = parent ^ AddrW'(1);
        pos_d       = parent;
        cur_d       = parent_val;
        if (parent == AddrW'(1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_QUERY: begin
        acc_l_d = acc_l_fold;
        acc_r_d = acc_r_fold;
        if (walk_more) begin
          take_l_d = lo_q[0];
          take_r_d = hi_q[0];
          lo_d     = (lo_q >> 1) + PosW'(lo_q[0]);
          hi_d     = hi_q >> 1;
        end else begin
          take_l_d = 1'b0;
          take_r_d = 1'b0;
          state_d  = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_min_d   = rmst_pkg::smin(acc_l_q, acc_r_q);
          out_empty_d = empty_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      cur_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      take_l_q    <= 1'b0;
      take_r_q    <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_min_q   <= '0;
      out_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pos_q       <= pos_d;
      cur_q       <= cur_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      acc_l_q     <= acc_l_d;
      acc_r_q     <= acc_r_d;
      take_l_q    <= take_l_d;
      take_r_q    <= take_r_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
      out_min_q   <= out_min_d;
      out_empty_q <= out_empty_d;
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.minimum     = out_min_q;
  assign out_o.range_empty = out_empty_q;

endmodule

// File: hw/rtl/rmst_checker.sv
// Port-level assertions for the range-min segment tree, bound to the top level.
module rmst_checker #(
  parameter int unsigned LEAVES = rmst_pkg::LeavesDef,
  localparam int unsigned LeafW  = $clog2(LEAVES),
  localparam int unsigned RangeW = $clog2(LEAVES + 1)
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_operation_i,
  input logic [LeafW-1:0]          in_leaf_index_i,
  input logic [RangeW-1:0]         in_range_start_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rmst_pkg::DataW-1:0] out_minimum_i,
  input logic                      out_range_empty_i
);

  logic in_beat;
  logic work_beat;

  assign in_beat   = in_valid_i && in_ready_i;
  assign work_beat = in_beat &&
                     ((in_operation_i == rmst_pkg::OP_QUERY) ||
                      ({1'b0, in_leaf_index_i} < (LeafW + 1)'(LEAVES)));

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_minimum_i) && $stable(out_range_empty_i))
    else $error("result beat changed while stalled");

  // Empty range always reports the largest signed value.
  a_empty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_range_empty_i |-> out_minimum_i == rmst_pkg::MaxVal)
    else $error("empty range with a minimum other than the largest value");

  // One operation at a time: a beat that starts work drops ready.
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_beat |=> !in_ready_i)
    else $error("request accepted while an operation is in flight");

  // Results only come out of the finish step, never straight from idle.
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared right after an idle cycle");

  // A query whose start is at or past the leaf count still occupies the block.
  a_start_beyond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_operation_i == rmst_pkg::OP_QUERY) &&
    (in_range_start_i >= RangeW'(LEAVES)) |=> !in_ready_i)
    else $error("query with out-of-range start did not occupy the block");

endmodule

bind range_min_segment_tree rmst_checker #(
  .LEAVES (LEAVES)
) u_rmst_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_operation_i    (in_i.operation),
  .in_leaf_index_i   (in_i.leaf_index),
  .in_range_start_i  (in_i.range_start),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_minimum_i     (out_o.minimum),
  .out_range_empty_i (out_o.range_empty)
);
